@@ rtl/fth_pkg.sv @@
// ----------------------------------------------------------------------------
// fth_pkg
// Shared types and constants for the frequency text to hertz converter.
// ----------------------------------------------------------------------------
package fth_pkg;

	localparam int CHAR_W  = 8;
	localparam int INT_W   = 32;
	localparam int FRAC_W  = 30;
	localparam int PROD_W  = INT_W + FRAC_W;
	localparam int FREQ_W  = PROD_W + 1;

	localparam logic [FRAC_W-1:0] SCALE_HZ  = 30'd1;
	localparam logic [FRAC_W-1:0] SCALE_KHZ = 30'd1000;
	localparam logic [FRAC_W-1:0] SCALE_MHZ = 30'd1000000;
	localparam logic [FRAC_W-1:0] SCALE_GHZ = 30'd1000000000;

	typedef enum logic [1:0] {
		UNIT_HZ  = 2'd0,
		UNIT_KHZ = 2'd1,
		UNIT_MHZ = 2'd2,
		UNIT_GHZ = 2'd3
	} unit_t;

	typedef struct packed {
		logic              matched;
		logic              negative;
		unit_t             unit;
		logic [INT_W-1:0]  base;
		logic [FRAC_W-1:0] scale;
		logic [FRAC_W-1:0] frac;
	} snap_t;

	function automatic logic [FRAC_W-1:0] pow10(input logic [3:0] n);
		logic [FRAC_W-1:0] r;
		unique case (n)
			4'd0:    r = 30'd1;
			4'd1:    r = 30'd10;
			4'd2:    r = 30'd100;
			4'd3:    r = 30'd1000;
			4'd4:    r = 30'd10000;
			4'd5:    r = 30'd100000;
			4'd6:    r = 30'd1000000;
			4'd7:    r = 30'd10000000;
			4'd8:    r = 30'd100000000;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/fth_scanner.sv @@
// ----------------------------------------------------------------------------
// fth_scanner
// Input register and per-character scan; snapshots the parse on the last item.
// ----------------------------------------------------------------------------
module fth_scanner (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       case_insensitive,
	input  logic                       text_valid,
	output logic                       text_stall,
	input  logic [fth_pkg::CHAR_W-1:0] text_char,
	input  logic                       last_char,
	output logic                       snap_valid,
	input  logic                       snap_ready,
	output fth_pkg::snap_t             snap
);
	import fth_pkg::*;

	typedef enum logic [2:0] {
		PH_SEEK  = 3'd0,
		PH_INT   = 3'd1,
		PH_FRAC  = 3'd2,
		PH_SPACE = 3'd3,
		PH_HWAIT = 3'd4,
		PH_DONE  = 3'd5
	} phase_t;

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              valid_s2;
	snap_t             snap_s2;

	phase_t            phase_q, phase_n;
	logic              neg_q, neg_n;
	logic [INT_W-1:0]  acc_q, acc_n;
	logic              ovf_q, ovf_n;
	logic [FRAC_W-1:0] f9_q, f9_n;
	logic [19:0]       f6_q, f6_n;
	logic [9:0]        f3_q, f3_n;
	logic [3:0]        d4_q, d4_n;
	logic [3:0]        d7_q, d7_n;
	logic [3:0]        d10_q, d10_n;
	logic [3:0]        cnt_q, cnt_n;
	unit_t             unit_q, unit_n;

	logic              ready2, fire1;
	logic              is_digit, is_space;
	logic              is_k, is_m, is_g, is_h, is_z;
	logic [3:0]        digit;
	logic [35:0]       acc_x10;
	logic [FRAC_W-1:0] f9_add;
	logic [19:0]       f6_add;
	logic [9:0]        f3_add;
	logic              unit_taken;
	logic              matched_n;
	logic [FRAC_W-1:0] frac_sel, scale_sel;
	snap_t             snap_n;

	assign ready2     = !valid_s2 || snap_ready;
	assign fire1      = valid_s1 && (!last_s1 || ready2);
	assign text_stall = valid_s1 && !fire1;

	assign digit    = char_s1[3:0];
	assign is_digit = (char_s1 >= 8'd48) && (char_s1 <= 8'd57);
	assign is_space = (char_s1 == 8'd32) || ((char_s1 >= 8'd9) && (char_s1 <= 8'd13));
	assign is_k     = (char_s1 == "k") || (case_insensitive && char_s1 == "K");
	assign is_m     = (char_s1 == "M") || (case_insensitive && char_s1 == "m");
	assign is_g     = (char_s1 == "G") || (case_insensitive && char_s1 == "g");
	assign is_h     = (char_s1 == "H") || (case_insensitive && char_s1 == "h");
	assign is_z     = (char_s1 == "z") || (case_insensitive && char_s1 == "Z");
	assign unit_taken = is_k || is_m || is_g || is_h;

	assign acc_x10 = {4'd0, acc_q} * 36'd10 + {32'd0, digit};
	assign f9_add  = FRAC_W'({26'd0, digit} * pow10(4'd8 - cnt_q));
	assign f6_add  = 20'({26'd0, digit} * pow10(4'd5 - cnt_q));
	assign f3_add  = 10'({26'd0, digit} * pow10(4'd2 - cnt_q));

	always_comb begin
		phase_n = phase_q;
		neg_n   = neg_q;
		acc_n   = acc_q;
		ovf_n   = ovf_q;
		f9_n    = f9_q;
		f6_n    = f6_q;
		f3_n    = f3_q;
		d4_n    = d4_q;
		d7_n    = d7_q;
		d10_n   = d10_q;
		cnt_n   = cnt_q;
		unit_n  = unit_q;
		unique case (phase_q)
			PH_SEEK: begin
				if (is_digit) begin
					acc_n   = {28'd0, digit};
					phase_n = PH_INT;
				end else if (char_s1 == "-") begin
					neg_n = 1'b1;
				end else if (!is_space) begin
					neg_n = 1'b0;
				end
			end
			PH_INT, PH_FRAC: begin
				if (is_digit && phase_q == PH_INT) begin
					if (!ovf_q) begin
						acc_n = acc_x10[INT_W-1:0];
						if (acc_x10[35:32] != 4'd0) ovf_n = 1'b1;
					end
				end else if (is_digit) begin
					if (cnt_q < 4'd9) begin
						f9_n  = f9_q + f9_add;
						cnt_n = cnt_q + 4'd1;
						if (cnt_q < 4'd6) f6_n = f6_q + f6_add;
						if (cnt_q < 4'd3) f3_n = f3_q + f3_add;
						if (cnt_q == 4'd3) d4_n = digit;
						if (cnt_q == 4'd6) d7_n = digit;
					end else if (cnt_q == 4'd9) begin
						d10_n = digit;
						cnt_n = 4'd10;
					end
				end else if (char_s1 == "." && phase_q == PH_INT) begin
					phase_n = PH_FRAC;
				end else if (is_space) begin
					phase_n = PH_SPACE;
				end else if (!unit_taken) begin
					phase_n = PH_DONE;
				end
			end
			PH_SPACE: begin
				if (!is_space && !unit_taken) phase_n = PH_DONE;
			end
			PH_HWAIT: begin
				if (is_z) unit_n = UNIT_HZ;
				phase_n = PH_DONE;
			end
			default: ;
		endcase
		if ((phase_q == PH_INT && !is_digit && char_s1 != "." && !is_space) ||
			(phase_q == PH_FRAC && !is_digit && !is_space) ||
			(phase_q == PH_SPACE && !is_space)) begin
			if (is_k) begin
				unit_n  = UNIT_KHZ;
				phase_n = PH_DONE;
			end else if (is_m) begin
				unit_n  = UNIT_MHZ;
				phase_n = PH_DONE;
			end else if (is_g) begin
				unit_n  = UNIT_GHZ;
				phase_n = PH_DONE;
			end else if (is_h) begin
				phase_n = PH_HWAIT;
			end
		end
	end

	always_comb begin
		matched_n = (phase_n != PH_SEEK);
		unique case (unit_n)
			UNIT_HZ: begin
				frac_sel  = '0;
				scale_sel = SCALE_HZ;
			end
			UNIT_KHZ: begin
				frac_sel  = {20'd0, f3_n} + FRAC_W'(d4_n >= 4'd5);
				scale_sel = SCALE_KHZ;
			end
			UNIT_MHZ: begin
				frac_sel  = {10'd0, f6_n} + FRAC_W'(d7_n >= 4'd5);
				scale_sel = SCALE_MHZ;
			end
			UNIT_GHZ: begin
				frac_sel  = f9_n + FRAC_W'(d10_n >= 4'd5);
				scale_sel = SCALE_GHZ;
			end
			default: begin
				frac_sel  = '0;
				scale_sel = SCALE_HZ;
			end
		endcase
		snap_n.matched  = matched_n;
		snap_n.negative = matched_n && neg_n;
		snap_n.unit     = matched_n ? unit_n : UNIT_HZ;
		snap_n.base     = (matched_n && !ovf_n) ? acc_n : '0;
		snap_n.scale    = scale_sel;
		snap_n.frac     = matched_n ? frac_sel : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			char_s1  <= '0;
			last_s1  <= 1'b0;
		end else if (!valid_s1 || fire1) begin
			valid_s1 <= text_valid;
			char_s1  <= text_char;
			last_s1  <= last_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			snap_s2  <= '0;
		end else if (ready2) begin
			valid_s2 <= fire1 && last_s1;
			if (fire1 && last_s1) snap_s2 <= snap_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			f9_q    <= '0;
			f6_q    <= '0;
			f3_q    <= '0;
			d4_q    <= '0;
			d7_q    <= '0;
			d10_q   <= '0;
			cnt_q   <= '0;
			unit_q  <= UNIT_MHZ;
		end else if (fire1) begin
			if (last_s1) begin
				phase_q <= PH_SEEK;
				neg_q   <= 1'b0;
				acc_q   <= '0;
				ovf_q   <= 1'b0;
				f9_q    <= '0;
				f6_q    <= '0;
				f3_q    <= '0;
				d4_q    <= '0;
				d7_q    <= '0;
				d10_q   <= '0;
				cnt_q   <= '0;
				unit_q  <= UNIT_MHZ;
			end else begin
				phase_q <= phase_n;
				neg_q   <= neg_n;
				acc_q   <= acc_n;
				ovf_q   <= ovf_n;
				f9_q    <= f9_n;
				f6_q    <= f6_n;
				f3_q    <= f3_n;
				d4_q    <= d4_n;
				d7_q    <= d7_n;
				d10_q   <= d10_n;
				cnt_q   <= cnt_n;
				unit_q  <= unit_n;
			end
		end
	end

	assign snap_valid = valid_s2;
	assign snap       = snap_s2;

`ifndef SYNTHESIS
	a_mid_item_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !last_s1 |-> !text_stall)
		else $error("non-final item stalled the input");
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire1 && last_s1 |=> phase_q == PH_SEEK && cnt_q == 4'd0 && unit_q == UNIT_MHZ)
		else $error("scan state not cleared after final item");
	a_ovf_needs_number: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> phase_q != PH_SEEK)
		else $error("overflow set while seeking a number");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'd10)
		else $error("fraction digit count out of range");
`endif

endmodule

@@ rtl/fth_scale.sv @@
// ----------------------------------------------------------------------------
// fth_scale
// Scales the parsed integer by the unit, adds the rounded fraction, signs it.
// ----------------------------------------------------------------------------
module fth_scale (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              snap_valid,
	output logic                              snap_ready,
	input  fth_pkg::snap_t                    snap,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic                              matched,
	output logic signed [fth_pkg::FREQ_W-1:0] frequency_hz,
	output logic [1:0]                        unit_code
);
	import fth_pkg::*;

	logic              valid_s3, valid_s4, valid_s5;
	logic              ready3, ready4, ready5;
	logic [PROD_W-1:0] prod_s3, mag_s4;
	logic [FRAC_W-1:0] frac_s3;
	logic              neg_s3, neg_s4;
	logic              match_s3, match_s4, match_s5;
	unit_t             unit_s3, unit_s4, unit_s5;
	logic [FREQ_W-1:0] freq_s5, mag_ext;

	assign ready5     = !valid_s5 || !result_stall;
	assign ready4     = !valid_s4 || ready5;
	assign ready3     = !valid_s3 || ready4;
	assign snap_ready = ready3;
	assign mag_ext    = {1'b0, mag_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			prod_s3  <= '0;
			frac_s3  <= '0;
			neg_s3   <= 1'b0;
			match_s3 <= 1'b0;
			unit_s3  <= UNIT_HZ;
		end else if (ready3) begin
			valid_s3 <= snap_valid;
			if (snap_valid) begin
				prod_s3  <= {30'd0, snap.base} * {32'd0, snap.scale};
				frac_s3  <= snap.frac;
				neg_s3   <= snap.negative;
				match_s3 <= snap.matched;
				unit_s3  <= snap.unit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			mag_s4   <= '0;
			neg_s4   <= 1'b0;
			match_s4 <= 1'b0;
			unit_s4  <= UNIT_HZ;
		end else if (ready4) begin
			valid_s4 <= valid_s3;
			if (valid_s3) begin
				mag_s4   <= prod_s3 + {32'd0, frac_s3};
				neg_s4   <= neg_s3;
				match_s4 <= match_s3;
				unit_s4  <= unit_s3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			freq_s5  <= '0;
			match_s5 <= 1'b0;
			unit_s5  <= UNIT_HZ;
		end else if (ready5) begin
			valid_s5 <= valid_s4;
			if (valid_s4) begin
				freq_s5  <= neg_s4 ? (~mag_ext + 63'd1) : mag_ext;
				match_s5 <= match_s4;
				unit_s5  <= unit_s4;
			end
		end
	end

	assign result_valid = valid_s5;
	assign matched      = match_s5;
	assign frequency_hz = freq_s5;
	assign unit_code    = unit_s5;

`ifndef SYNTHESIS
	a_neg_needs_match: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frequency_hz[FREQ_W-1] |-> matched)
		else $error("negative frequency without a match");
	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !matched |-> frequency_hz == '0 && unit_code == UNIT_HZ)
		else $error("unmatched item carries a value");
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && !ready5 |=> valid_s4 && $stable(mag_s4))
		else $error("sum stage lost its item under stall");
`endif

endmodule

@@ rtl/frequency_text_to_hertz.sv @@
// ----------------------------------------------------------------------------
// frequency_text_to_hertz
// Converts a frequency string, one character per item, into signed hertz.
// ----------------------------------------------------------------------------
// Input channel text_valid/text_stall carries text_char and last_char; an item
// moves at an edge with valid high and stall low, at one item per cycle.
// Output channel result_valid/result_stall carries matched, frequency_hz and
// unit_code: one result per string, for the item with last_char set.
// The result is valid once the final character has passed the input register,
// scan and snapshot, unit multiply, fraction add and sign stage. Throughput
// is one character per cycle while text_stall is low, set by the single
// character scan register update; strings may follow back to back.
// A stalled result holds its value; the pipeline behind it keeps filling and
// input stall rises only once the scan snapshot can no longer advance, and
// then only for a final character.
// cfg_write_en writes cfg_write_data into the case-insensitive unit flag at
// the next edge; write it only while idle.
// Reset clears the pipeline, the scan state and the flag; no clearing pass.
// ----------------------------------------------------------------------------
module frequency_text_to_hertz (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic                              cfg_write_data,
	input  logic                              text_valid,
	output logic                              text_stall,
	input  logic [fth_pkg::CHAR_W-1:0]        text_char,
	input  logic                              last_char,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic                              matched,
	output logic signed [fth_pkg::FREQ_W-1:0] frequency_hz,
	output logic [1:0]                        unit_code
);
	import fth_pkg::*;

	logic  case_insensitive_q;
	logic  snap_valid, snap_ready;
	snap_t snap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			case_insensitive_q <= 1'b0;
		end else if (cfg_write_en) begin
			case_insensitive_q <= cfg_write_data;
		end
	end

	fth_scanner u_scanner (
		.clk              (clk),
		.arst_n           (arst_n),
		.case_insensitive (case_insensitive_q),
		.text_valid       (text_valid),
		.text_stall       (text_stall),
		.text_char        (text_char),
		.last_char        (last_char),
		.snap_valid       (snap_valid),
		.snap_ready       (snap_ready),
		.snap             (snap)
	);

	fth_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.snap_valid   (snap_valid),
		.snap_ready   (snap_ready),
		.snap         (snap),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.matched      (matched),
		.frequency_hz (frequency_hz),
		.unit_code    (unit_code)
	);

endmodule
